// ===== rtl/core/itfb_pkg.sv =====
`timescale 1ns / 1ps
package itfb_pkg;

   localparam int FRAME_LEN     = 64;
   localparam int IDX_W         = $clog2(FRAME_LEN);
   localparam int NUM_VALUES    = 6;
   localparam int VAL_IDX_W     = $clog2(NUM_VALUES);
   localparam int PAYLOAD_FIRST = 10;
   localparam int PAYLOAD_LAST  = PAYLOAD_FIRST + 4 * NUM_VALUES - 1;

   localparam logic [7:0]  SYNC_BYTE   = 8'h55;
   localparam logic [7:0]  OP_START    = 8'h04;
   localparam logic [7:0]  OP_STOP     = 8'h05;
   localparam logic [23:0] ACC_Q24     = 24'd10036225;
   localparam logic [5:0]  RATE_NUM    = 6'd35;
   localparam logic [15:0] PERIOD_INIT = 16'd125;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_CMD  = 2'd1;
   localparam logic [1:0] KIND_SEND = 2'd2;

   typedef logic signed [15:0] raw_type;
   typedef logic [31:0]        value_type;

endpackage

// ===== rtl/core/itfb_if.sv =====
`timescale 1ns / 1ps
interface itfb_req_if;
   import itfb_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] period_ms;
   logic [7:0]  opcode;
   raw_type     accel_x;
   raw_type     accel_y;
   raw_type     accel_z;
   raw_type     rate_x;
   raw_type     rate_y;
   raw_type     rate_z;

   modport source (output valid, kind, period_ms, opcode, accel_x, accel_y, accel_z,
                   rate_x, rate_y, rate_z, input ready);
   modport sink (input valid, kind, period_ms, opcode, accel_x, accel_y, accel_z,
                 rate_x, rate_y, rate_z, output ready);
endinterface

interface itfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;

   modport source (output valid, tx_byte, last_byte, input ready);
   modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

interface itfb_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/itfb_scale.sv =====
`timescale 1ns / 1ps
module itfb_scale
   import itfb_pkg::*;
(
   input  raw_type   accel_raw [3],
   input  raw_type   rate_raw [3],
   output value_type values [NUM_VALUES]
);

   function automatic logic [16:0] magnitude(input raw_type raw);
      logic [16:0] ext;
      ext = {raw[15], raw};
      return raw[15] ? (~ext + 17'd1) : ext;
   endfunction

   function automatic value_type apply_sign(input logic neg, input logic [19:0] mag);
      value_type ext;
      ext = {12'd0, mag};
      return neg ? (~ext + 32'd1) : ext;
   endfunction

   function automatic value_type scale_accel(input raw_type raw);
      logic [40:0] prod;
      prod = 41'(magnitude(raw)) * 41'(ACC_Q24);
      return apply_sign(raw[15], {3'd0, prod[40:24]});
   endfunction

   function automatic value_type scale_rate(input raw_type raw);
      logic [22:0] prod;
      prod = 23'(magnitude(raw)) * 23'(RATE_NUM);
      return apply_sign(raw[15], prod[22:3]);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         values[i]     = scale_accel(accel_raw[i]);
         values[i + 3] = scale_rate(rate_raw[i]);
      end
   end

endmodule

// ===== rtl/core/imu_telemetry_frame_builder.sv =====
`timescale 1ns / 1ps
// Paced telemetry framer. Every accepted word on req is registered and then
// updates the tick accumulator, the report mode and the frame count as it
// leaves that register; words that cause no frame leave at one per cycle. A
// word that causes a frame scales the six sensor samples into a frame slot and
// waits until that slot is free. The byte counter of the serializer sends one
// rsp word per cycle while rsp is ready. The slot is freed only after the last
// byte is loaded, so a following frame cannot be loaded in the same cycle as
// that last byte. The first byte passes the request register, the frame slot
// and the rsp register. The checksum is summed while the bytes go out. The
// period register on csr is always ready and should be written only while idle.
module imu_telemetry_frame_builder
   import itfb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   itfb_req_if.sink   req,
   itfb_rsp_if.source rsp,
   itfb_csr_if.sink   csr
);

   logic [15:0] period_ff;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [7:0]  count_ff;
   logic        report_ff;

   logic        a_valid_ff;
   logic [1:0]  a_kind_ff;
   logic [15:0] a_period_ff;
   logic [7:0]  a_opcode_ff;
   raw_type     a_accel_ff [3];
   raw_type     a_rate_ff [3];

   logic        frame_valid_ff;
   logic        frame_report_ff;
   logic [7:0]  frame_count_ff;
   value_type   frame_values_ff [NUM_VALUES];
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]  sum_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   value_type   scaled [NUM_VALUES];
   logic        fire_a, a_adv, out_load;
   logic [7:0]  byte_sel;
   logic [4:0]  pay_off;

   itfb_scale u_scale (
      .accel_raw (a_accel_ff),
      .rate_raw  (a_rate_ff),
      .values    (scaled)
   );

   assign csr.ready = 1'b1;

   assign elapsed_in = elapsed_ff + {1'b0, a_period_ff};
   always_comb begin
      case (a_kind_ff)
         KIND_TICK: fire_a = (elapsed_in >= {1'b0, period_ff});
         KIND_SEND: fire_a = 1'b1;
         default:   fire_a = 1'b0;
      endcase
   end
   assign a_adv     = a_valid_ff && (!fire_a || !frame_valid_ff);
   assign req.ready = !a_valid_ff || a_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_INIT;
         elapsed_ff <= '0;
         count_ff   <= '0;
         report_ff  <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            period_ff <= csr.data;
         end
         if (req.valid && req.ready) begin
            a_valid_ff <= 1'b1;
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
         if (a_adv) begin
            if (a_kind_ff == KIND_TICK) begin
               elapsed_ff <= fire_a ? '0 : elapsed_in;
            end
            if (a_kind_ff == KIND_CMD) begin
               if (a_opcode_ff == OP_START) begin
                  report_ff <= 1'b1;
               end else if (a_opcode_ff == OP_STOP) begin
                  report_ff <= 1'b0;
               end
            end
            if (fire_a) begin
               count_ff <= count_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         a_kind_ff     <= req.kind;
         a_period_ff   <= req.period_ms;
         a_opcode_ff   <= req.opcode;
         a_accel_ff[0] <= req.accel_x;
         a_accel_ff[1] <= req.accel_y;
         a_accel_ff[2] <= req.accel_z;
         a_rate_ff[0]  <= req.rate_x;
         a_rate_ff[1]  <= req.rate_y;
         a_rate_ff[2]  <= req.rate_z;
      end
      if (a_adv && fire_a) begin
         frame_report_ff <= report_ff;
         frame_count_ff  <= count_ff + 8'd1;
         frame_values_ff <= scaled;
      end
   end

   assign pay_off = 5'(idx_ff - IDX_W'(PAYLOAD_FIRST));
   always_comb begin
      if (idx_ff == IDX_W'(1)) begin
         byte_sel = frame_count_ff;
      end else if (idx_ff == IDX_W'(2) || idx_ff == IDX_W'(3)) begin
         byte_sel = SYNC_BYTE;
      end else if (idx_ff == IDX_W'(FRAME_LEN - 1)) begin
         byte_sel = sum_ff;
      end else if (frame_report_ff && idx_ff >= IDX_W'(PAYLOAD_FIRST)
                   && idx_ff <= IDX_W'(PAYLOAD_LAST)) begin
         case (pay_off[1:0])
            2'd0:    byte_sel = frame_values_ff[pay_off[2+VAL_IDX_W-1:2]][31:24];
            2'd1:    byte_sel = frame_values_ff[pay_off[2+VAL_IDX_W-1:2]][23:16];
            2'd2:    byte_sel = frame_values_ff[pay_off[2+VAL_IDX_W-1:2]][15:8];
            default: byte_sel = frame_values_ff[pay_off[2+VAL_IDX_W-1:2]][7:0];
         endcase
      end else begin
         byte_sel = 8'h00;
      end
   end

   assign out_load = frame_valid_ff && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         idx_ff         <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (a_adv && fire_a) begin
            frame_valid_ff <= 1'b1;
         end else if (out_load && idx_ff == IDX_W'(FRAME_LEN - 1)) begin
            frame_valid_ff <= 1'b0;
         end
         if (out_load) begin
            idx_ff       <= idx_ff + IDX_W'(1);
            sum_ff       <= (idx_ff == IDX_W'(FRAME_LEN - 1)) ? 8'h00 : sum_ff + byte_sel;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_ff <= byte_sel;
         rsp_last_ff <= (idx_ff == IDX_W'(FRAME_LEN - 1));
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.tx_byte   = rsp_byte_ff;
   assign rsp.last_byte = rsp_last_ff;

   a_no_frame_overwrite: assert property (@(posedge clock) disable iff (reset)
      (a_adv && fire_a) |-> !frame_valid_ff)
      else $error("frame slot loaded while a frame is still being sent");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (idx_ff == '0))
      else $error("last byte shown with the byte counter off frame start");

   a_first_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (out_load && idx_ff == '0) |=> (rsp_byte_ff == 8'h00 && !rsp_last_ff))
      else $error("frame did not open with a zero byte");

   a_tick_fire_clears: assert property (@(posedge clock) disable iff (reset)
      (a_adv && fire_a && a_kind_ff == KIND_TICK) |=> (elapsed_ff == '0))
      else $error("accumulator not cleared after a paced frame");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import itfb_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         TAIL_CYCLES = 80;

   typedef struct {
      logic [1:0]   kind;
      logic [15:0]  ms;
      logic [7:0]   opcode;
      raw_type [5:0] smp;
   } imu_word_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic clock;
   logic reset;

   itfb_req_if req_if ();
   itfb_rsp_if rsp_if ();
   itfb_csr_if csr_if ();

   imu_telemetry_frame_builder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   imu_word_type   word_q[$];
   frame_byte_type frame_byte_q[$];

   logic [15:0] period_cfg = PERIOD_INIT;
   logic [16:0] elapsed_acc = '0;
   logic [7:0]  frame_cnt = '0;
   logic        reports_on = 1'b0;

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   err_cnt = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_mode = 0;
   int   stall_left = 0;
   int   rx_cycle = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   function automatic value_type scale_sample(input raw_type raw, input bit is_accel);
      logic [16:0] mag;
      logic [63:0] prod;
      value_type   q;
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      if (is_accel) begin
         prod = (64'(mag) * 64'(ACC_Q24)) >> 24;
      end else begin
         prod = (64'(mag) * 64'(RATE_NUM)) >> 3;
      end
      q = prod[31:0];
      return raw[15] ? (32'd0 - q) : q;
   endfunction

   task automatic queue_frame(input imu_word_type w);
      logic [7:0] f[FRAME_LEN];
      logic [7:0] sum;
      value_type  v;
      frame_byte_type e;
      frame_cnt = frame_cnt + 8'd1;
      foreach (f[i]) f[i] = 8'h00;
      f[1] = frame_cnt;
      f[2] = SYNC_BYTE;
      f[3] = SYNC_BYTE;
      if (reports_on) begin
         for (int i = 0; i < NUM_VALUES; i++) begin
            v = scale_sample(w.smp[i], i < 3);
            f[PAYLOAD_FIRST + 4 * i]     = v[31:24];
            f[PAYLOAD_FIRST + 4 * i + 1] = v[23:16];
            f[PAYLOAD_FIRST + 4 * i + 2] = v[15:8];
            f[PAYLOAD_FIRST + 4 * i + 3] = v[7:0];
         end
      end
      sum = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + f[i];
      f[FRAME_LEN - 1] = sum;
      for (int i = 0; i < FRAME_LEN; i++) begin
         e.data = f[i];
         e.last = (i == FRAME_LEN - 1);
         frame_byte_q.push_back(e);
      end
   endtask

   task automatic apply_word(input imu_word_type w);
      case (w.kind)
         KIND_TICK: begin
            elapsed_acc = elapsed_acc + {1'b0, w.ms};
            if (elapsed_acc >= {1'b0, period_cfg}) begin
               elapsed_acc = '0;
               queue_frame(w);
            end
         end
         KIND_CMD: begin
            if (w.opcode == OP_START) reports_on = 1'b1;
            else if (w.opcode == OP_STOP) reports_on = 1'b0;
         end
         KIND_SEND: queue_frame(w);
         default: ;
      endcase
   endtask

   function automatic raw_type rand_sample();
      case ($urandom_range(0, 11))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return raw_type'($urandom);
      endcase
   endfunction

   function automatic imu_word_type make_word(input logic [1:0] k, input logic [15:0] ms,
                                              input logic [7:0] op);
      imu_word_type w;
      w.kind = k;
      w.ms = ms;
      w.opcode = op;
      for (int i = 0; i < NUM_VALUES; i++) w.smp[i] = rand_sample();
      return w;
   endfunction

   function automatic imu_word_type random_word(input logic [15:0] per);
      int         pick;
      logic [15:0] ms;
      logic [7:0] op;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1: ms = 16'd0;
         2: ms = 16'($urandom);
         default: ms = 16'($urandom_range(1, int'(per) / 2 + 1));
      endcase
      case ($urandom_range(0, 9))
         0: op = 8'($urandom);
         1, 2, 3, 4: op = OP_START;
         default: op = OP_STOP;
      endcase
      if (pick < 40) return make_word(KIND_TICK, ms, 8'($urandom));
      if (pick < 55) return make_word(KIND_CMD, 16'($urandom), op);
      if (pick < 95) return make_word(KIND_SEND, 16'($urandom), 8'($urandom));
      return make_word(KIND_UNUSED, 16'($urandom), 8'($urandom));
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (word_q.size() != 0 || req_if.valid || frame_byte_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      @(negedge clock);
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(negedge clock);
      while (!csr_taken);
      csr_if.valid <= 1'b0;
   endtask

   // Requests go out in bursts; a held word stays put until it is taken.
   always @(negedge clock) begin
      imu_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (word_q.size() == 0) begin
            req_if.valid <= 1'b0;
         end else begin
            w = word_q.pop_front();
            req_if.kind      <= w.kind;
            req_if.period_ms <= w.ms;
            req_if.opcode    <= w.opcode;
            req_if.accel_x   <= w.smp[0];
            req_if.accel_y   <= w.smp[1];
            req_if.accel_z   <= w.smp[2];
            req_if.rate_x    <= w.smp[3];
            req_if.rate_y    <= w.smp[4];
            req_if.rate_z    <= w.smp[5];
            req_if.valid     <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_if.ready <= (rx_cycle % 8) < 3;
      endcase
   end

   always @(posedge clock) begin
      imu_word_type   w;
      frame_byte_type e;
      req_taken <= !reset && req_if.valid && req_if.ready;
      csr_taken <= !reset && csr_if.valid && csr_if.ready;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) period_cfg = csr_if.data;
         if (req_if.valid && req_if.ready) begin
            w.kind   = req_if.kind;
            w.ms     = req_if.period_ms;
            w.opcode = req_if.opcode;
            w.smp[0] = req_if.accel_x;
            w.smp[1] = req_if.accel_y;
            w.smp[2] = req_if.accel_z;
            w.smp[3] = req_if.rate_x;
            w.smp[4] = req_if.rate_y;
            w.smp[5] = req_if.rate_z;
            apply_word(w);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_byte_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected word tx_byte=%02h last_byte=%0b",
                                       rsp_if.tx_byte, rsp_if.last_byte));
            end else begin
               e = frame_byte_q.pop_front();
               if (rsp_if.tx_byte !== e.data)
                  flag_mismatch($sformatf("tx_byte %02h, expected %02h",
                                          rsp_if.tx_byte, e.data));
               if (rsp_if.last_byte !== e.last)
                  flag_mismatch($sformatf("last_byte %0b, expected %0b",
                                          rsp_if.last_byte, e.last));
            end
         end
      end
   end

   initial begin
      imu_word_type w;
      logic [15:0]  per;
      int           n;
      bit           paused;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = KIND_TICK;
      req_if.period_ms = '0;
      req_if.opcode = '0;
      req_if.accel_x = '0;
      req_if.accel_y = '0;
      req_if.accel_z = '0;
      req_if.rate_x = '0;
      req_if.rate_y = '0;
      req_if.rate_z = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The default period is used first, with heartbeat and report frames.
      word_q.push_back(make_word(KIND_SEND, 16'd0, 8'd0));
      word_q.push_back(make_word(KIND_CMD, 16'd0, OP_START));
      w = make_word(KIND_SEND, 16'd0, 8'd0);
      for (int i = 0; i < NUM_VALUES; i++) w.smp[i] = 16'sh7FFF;
      word_q.push_back(w);
      for (int i = 0; i < NUM_VALUES; i++) w.smp[i] = 16'sh8000;
      word_q.push_back(w);
      w.smp[0] = 16'sh0000;
      w.smp[1] = 16'shFFFF;
      w.smp[2] = 16'sh0001;
      w.smp[3] = 16'shFFFF;
      w.smp[4] = 16'sh0001;
      w.smp[5] = 16'shFFFE;
      word_q.push_back(w);
      word_q.push_back(make_word(KIND_TICK, 16'd100, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'd24, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'd1, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'd0, 8'd0));
      word_q.push_back(make_word(KIND_UNUSED, 16'hFFFF, 8'hFF));
      word_q.push_back(make_word(KIND_CMD, 16'd0, 8'h00));
      word_q.push_back(make_word(KIND_CMD, 16'd0, 8'hFF));
      word_q.push_back(make_word(KIND_CMD, 16'd0, OP_STOP));
      word_q.push_back(make_word(KIND_TICK, 16'hFFFF, 8'd0));
      word_q.push_back(make_word(KIND_SEND, 16'd0, 8'd0));
      wait_drained();

      write_period(16'hFFFF);
      word_q.push_back(make_word(KIND_TICK, 16'hFFFE, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'd1, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'hFFFF, 8'd0));
      word_q.push_back(make_word(KIND_CMD, 16'd0, OP_START));
      word_q.push_back(make_word(KIND_TICK, 16'd30000, 8'd0));
      wait_drained();

      // A period lowered below the accumulated time fires on a zero tick.
      write_period(16'd10);
      word_q.push_back(make_word(KIND_TICK, 16'd0, 8'd0));
      wait_drained();

      write_period(16'd0);
      word_q.push_back(make_word(KIND_TICK, 16'd0, 8'd0));
      word_q.push_back(make_word(KIND_TICK, 16'd5, 8'd0));
      wait_drained();

      paused = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: per = 16'd1;
            1: per = 16'($urandom_range(2, 40));
            2: per = 16'($urandom_range(40, 400));
            3: per = 16'hFFFF;
            default: per = 16'($urandom_range(0, 30));
         endcase
         write_period(per);
         n = 0;
         while (n < 50) begin
            w = random_word(per);
            word_q.push_back(w);
            if (w.kind != KIND_UNUSED &&
                !(w.kind == KIND_CMD && w.opcode != OP_START && w.opcode != OP_STOP)) begin
               n++;
               if (ph == 2 && n == 25 && !paused) begin
                  wait_drained();
                  paused = 1'b1;
               end
            end
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
